// ===== rtl/sliding_window_vq_histogram_top_defines.svh =====
// Assertion macros shared by the block's checks
`ifndef SLIDING_WINDOW_VQ_HISTOGRAM_TOP_DEFINES_SVH
`define SLIDING_WINDOW_VQ_HISTOGRAM_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define SWVQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWVQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swvq_pkg.sv =====
`timescale 1ns / 1ps
package swvq_pkg;
    localparam int DefMaxWindow   = 16;
    localparam int DefMaxClusters = 16;
    localparam int DefSampleWidth = 16;
    localparam int DefCountWidth  = 24;

    localparam logic [1:0] ModeLoad   = 2'd0;
    localparam logic [1:0] ModeSample = 2'd1;
    localparam logic [1:0] ModeEnd    = 2'd2;

    localparam logic [1:0] CfgWinLen  = 2'd0;
    localparam logic [1:0] CfgClust   = 2'd1;
    localparam logic [1:0] CfgNorm    = 2'd2;

    // divider control between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [47:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] quotient;
    } t_div_rsp;
endpackage

// ===== rtl/sliding_window_vq_histogram_top.sv =====
`timescale 1ns / 1ps
// Sliding-window vector-quantisation histogram.
// Channels: input items (mode, centroid_index, element_index, value) on
// i_valid/o_ready; result items (bin_index, bin_value, last) on
// o_valid/i_ready; register writes on i_cfg_valid/o_cfg_ready.
// A load item passes through the load state back to idle. A sample
// item with a full window runs the one shared squared-difference
// accumulator over the window for each centroid in turn, with its
// pipeline drain per centroid before the compare; otherwise it only
// shifts the window. An end item sums the bins one a cycle, then emits
// the bins in turn; with normalise each bin waits on the bit-serial
// divider. Input is not accepted while an item is in work.
// Reset sets registers to 16, 16, 0, clears window, bins and counters;
// the centroid memory is not cleared. A stalled receiver holds the
// result register and the sequencer waits; nothing is lost.
`include "sliding_window_vq_histogram_top_defines.svh"
module sliding_window_vq_histogram_top #(
    parameter int MaxWindow   = swvq_pkg::DefMaxWindow,
    parameter int MaxClusters = swvq_pkg::DefMaxClusters,
    parameter int SampleWidth = swvq_pkg::DefSampleWidth,
    parameter int CountWidth  = swvq_pkg::DefCountWidth
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_mode,
    input  logic [3:0]             i_centroid_index,
    input  logic [3:0]             i_element_index,
    input  logic [SampleWidth-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [3:0]             o_bin_index,
    output logic [23:0]            o_bin_value,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    localparam int WB = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
    localparam int CB = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
    localparam int MD = MaxClusters * MaxWindow;
    localparam int AB = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [CountWidth-1:0] CntMax = '1;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMac  = 3'd1;
    localparam logic [2:0] StCmp  = 3'd2;
    localparam logic [2:0] StSum  = 3'd3;
    localparam logic [2:0] StBin  = 3'd4;
    localparam logic [2:0] StDiv  = 3'd5;
    localparam logic [2:0] StOut  = 3'd6;
    localparam logic [2:0] StLoad = 3'd7;

    // configuration
    logic [4:0] r_win_len, r_clusters;
    logic       r_norm;
    logic [6:0] w_len, w_nc;
    always_comb begin
        w_len = (r_win_len == 5'd0) ? 7'd1
              : (7'(r_win_len) > 7'(MaxWindow)) ? 7'(MaxWindow) : 7'(r_win_len);
        w_nc  = (r_clusters == 5'd0) ? 7'd1
              : (7'(r_clusters) > 7'(MaxClusters)) ? 7'(MaxClusters) : 7'(r_clusters);
    end

    logic [2:0] r_state;
    assign o_ready     = (r_state == StIdle);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= 5'd16;
            r_clusters <= 5'd16;
            r_norm     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swvq_pkg::CfgWinLen: r_win_len  <= i_cfg_data[4:0];
                swvq_pkg::CfgClust:  r_clusters <= i_cfg_data[4:0];
                swvq_pkg::CfgNorm:   r_norm     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // centroid memory, one read port registered
    logic [SampleWidth-1:0] r_cmem [MD];
    logic [SampleWidth-1:0] r_cdata;
    logic [AB-1:0]          w_raddr;
    logic [SampleWidth-1:0] r_load_v;
    logic [AB-1:0]          r_load_a;
    logic                   r_load_we;
    always_ff @(posedge i_clk) begin
        if (r_load_we) r_cmem[r_load_a] <= r_load_v;
        r_cdata <= r_cmem[w_raddr];
    end

    // load item: write captured at acceptance, done in the following cycle
    always_ff @(posedge i_clk) begin
        r_load_we <= i_rst_n && o_ready && i_valid && (i_mode == swvq_pkg::ModeLoad) &&
                     (32'(i_centroid_index) < MaxClusters) &&
                     (32'(i_element_index) < MaxWindow);
        r_load_a  <= AB'(32'(i_centroid_index) * MaxWindow + 32'(i_element_index));
        r_load_v  <= i_value;
    end

    // window line, index 0 newest
    logic [SampleWidth-1:0] r_win [MaxWindow];
    logic [SampleWidth-1:0] r_xdata;
    logic [23:0]            r_seen;
    logic [CountWidth-1:0]  r_bins [MaxClusters];

    // sequencer
    logic [CB:0]   r_c;
    logic [WB:0]   r_j;
    logic [2:0]    r_drain;
    logic [63:0]   r_best_d;
    logic [CB-1:0] r_best;
    logic          r_have;
    logic [CountWidth+CB:0] r_total;
    logic [SampleWidth-1:0] r_smp;
    logic [63:0]   w_acc;
    logic          w_mac_clr, w_mac_en;
    logic          r_ovalid;
    logic [3:0]    r_obin;
    logic [23:0]   r_oval;
    logic          r_olast;
    logic [WB-1:0] w_xidx;
    swvq_pkg::t_div_req w_dreq;
    swvq_pkg::t_div_rsp w_drsp;

    assign w_xidx    = WB'(w_len - 7'd1 - 7'(r_j));
    assign w_raddr   = AB'(32'(r_c[CB-1:0]) * MaxWindow + 32'(r_j[WB-1:0]));
    // operands of element j arrive in the cycle after its address
    assign w_mac_en  = (r_state == StMac) &&
                       (((r_drain == 3'd0) && (r_j != '0)) || (r_drain == 3'd1));
    assign w_mac_clr = (r_state == StIdle) || (r_state == StCmp);

    always_ff @(posedge i_clk) r_xdata <= r_win[w_xidx];

    swvq_mac #(.SampleWidth(SampleWidth)) u_mac (
        .i_clk (i_clk), .i_clr (w_mac_clr), .i_en (w_mac_en),
        .i_a (r_cdata), .i_b (r_xdata), .o_acc (w_acc)
    );

    assign w_dreq.start    = (r_state == StBin) && r_norm && !r_ovalid;
    assign w_dreq.dividend = 48'({r_bins[r_c[CB-1:0]], 16'd0});
    assign w_dreq.divisor  = (r_total == '0) ? 48'd1 : 48'(r_total);

    swvq_div u_div (.i_clk (i_clk), .i_rst_n (i_rst_n), .i_req (w_dreq), .o_rsp (w_drsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_seen   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < MaxWindow; k++) r_win[k] <= '0;
            for (int k = 0; k < MaxClusters; k++) r_bins[k] <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                StIdle: if (i_valid) begin
                    r_smp <= i_value;
                    r_c <= '0; r_j <= '0; r_drain <= 3'd0; r_have <= 1'b0;
                    r_total <= '0;
                    unique case (i_mode)
                        swvq_pkg::ModeLoad:   r_state <= StLoad;
                        swvq_pkg::ModeSample: r_state <= StMac;
                        swvq_pkg::ModeEnd:    r_state <= StSum;
                        default:              r_state <= StIdle;
                    endcase
                end
                StLoad: r_state <= StIdle;
                StMac: begin
                    if (32'(r_seen) < 32'(w_len)) begin
                        // no full window yet: shift only
                        for (int k = MaxWindow - 1; k > 0; k--) r_win[k] <= r_win[k-1];
                        r_win[0] <= r_smp;
                        r_seen   <= r_seen + 24'd1;
                        r_state  <= StIdle;
                    end else if (r_drain != 3'd0) begin
                        r_drain <= r_drain + 3'd1;
                        if (r_drain == 3'd4) r_state <= StCmp;
                    end else if (7'(r_j) == w_len - 7'd1) begin
                        r_drain <= 3'd1;
                    end else begin
                        r_j <= r_j + (WB+1)'(1);
                    end
                end
                StCmp: begin
                    if (!r_have || w_acc < r_best_d) begin
                        r_have <= 1'b1; r_best_d <= w_acc; r_best <= r_c[CB-1:0];
                    end
                    r_j <= '0; r_drain <= 3'd0;
                    if (7'(r_c) == w_nc - 7'd1) begin
                        // winner known after this compare
                        if (!r_have || w_acc < r_best_d) begin
                            if (r_bins[r_c[CB-1:0]] != CntMax)
                                r_bins[r_c[CB-1:0]] <= r_bins[r_c[CB-1:0]] + CountWidth'(1);
                        end else if (r_bins[r_best] != CntMax) begin
                            r_bins[r_best] <= r_bins[r_best] + CountWidth'(1);
                        end
                        for (int k = MaxWindow - 1; k > 0; k--) r_win[k] <= r_win[k-1];
                        r_win[0] <= r_smp;
                        if (r_seen != 24'hFFFFFF) r_seen <= r_seen + 24'd1;
                        r_state <= StIdle;
                    end else begin
                        r_c <= r_c + (CB+1)'(1);
                        r_state <= StMac;
                    end
                end
                StSum: begin
                    r_total <= r_total + (CountWidth+CB+1)'(r_bins[r_c[CB-1:0]]);
                    if (7'(r_c) == w_nc - 7'd1) begin
                        r_c <= '0; r_state <= StBin;
                    end else r_c <= r_c + (CB+1)'(1);
                end
                StBin: if (!r_ovalid) begin
                    if (r_norm) r_state <= StDiv;
                    else begin
                        r_oval <= 24'(r_bins[r_c[CB-1:0]]);
                        r_state <= StOut;
                    end
                end
                StDiv: if (w_drsp.done) begin
                    r_oval  <= w_drsp.quotient[23:0];
                    r_state <= StOut;
                end
                StOut: begin
                    r_ovalid <= 1'b1;
                    r_obin   <= 4'(r_c);
                    r_olast  <= (7'(r_c) == w_nc - 7'd1);
                    if (7'(r_c) == w_nc - 7'd1) begin
                        for (int k = 0; k < MaxWindow; k++) r_win[k] <= '0;
                        for (int k = 0; k < MaxClusters; k++) r_bins[k] <= '0;
                        r_seen  <= '0;
                        r_state <= StIdle;
                    end else begin
                        r_c <= r_c + (CB+1)'(1);
                        r_state <= StBin;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_bin_index = r_obin;
    assign o_bin_value = r_oval;
    assign o_last      = r_olast;

    `SWVQ_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != StIdle, !o_ready, "ready while busy")
    `SWVQ_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, w_dreq.start, !w_drsp.busy, "divider restarted")
    `SWVQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_bin_value), "result dropped")
endmodule

// ===== rtl/swvq_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle
module swvq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swvq_pkg::t_div_req i_req,
    output swvq_pkg::t_div_rsp o_rsp
);
    logic [47:0] r_quo, n_quo;
    logic [47:0] r_rem, n_rem;
    logic [47:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [48:0] w_trial;

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quo[47]};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract if it fits
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = 48'(w_trial - {1'b0, r_den});
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = w_trial[47:0];
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.divisor;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== rtl/swvq_mac.sv =====
`timescale 1ns / 1ps
// Shared squared-difference accumulate unit: one element per cycle,
// the product registered before the saturating add.
module swvq_mac #(
    parameter int SampleWidth = swvq_pkg::DefSampleWidth
) (
    input  logic                   i_clk,
    input  logic                   i_clr,
    input  logic                   i_en,
    input  logic [SampleWidth-1:0] i_a,
    input  logic [SampleWidth-1:0] i_b,
    output logic [63:0]            o_acc
);
    localparam int DW = SampleWidth + 1;
    logic signed [DW-1:0] w_diff;
    logic [DW-1:0]        w_abs;
    logic [2*DW-1:0]      r_sq;
    logic                 r_vld;
    logic [63:0]          r_acc;
    logic [64:0]          w_sum;

    assign w_diff = DW'($signed(i_a)) - DW'($signed(i_b));
    assign w_abs  = w_diff[DW-1] ? DW'(-w_diff) : DW'(w_diff);
    assign w_sum  = {1'b0, r_acc} + 65'(r_sq);

    always_ff @(posedge i_clk) begin
        r_sq  <= w_abs * w_abs;
        r_vld <= i_en;
        if (i_clr) r_acc <= '0;
        else if (r_vld) r_acc <= w_sum[64] ? '1 : w_sum[63:0];
    end

    assign o_acc = r_acc;
endmodule

// ===== sim/sliding_window_vq_histogram_top_tb.sv =====
`timescale 1ns / 1ps
module sliding_window_vq_histogram_top_tb;

    localparam logic [1:0] ModeIgnored = 2'd3;
    localparam int SettleCycles = 400;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  centroid;
        logic [3:0]  element;
        logic [15:0] value;
    } t_vq_item;

    typedef struct {
        logic [3:0]  bin;
        logic [23:0] count;
        logic        last;
    } t_bin_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [3:0]  i_centroid_index = '0;
    logic [3:0]  i_element_index = '0;
    logic [15:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_bin_index;
    logic [23:0] o_bin_value;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    sliding_window_vq_histogram_top dut (.*);

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_vq_item  pending_items[$];
    t_bin_item bins_due[$];
    int        errors = 0;
    bit        calm = 1'b0;
    bit        long_hold_req = 1'b0;
    bit        item_taken = 1'b0;

    // predictor state
    logic [4:0]         win_len_reg;
    logic [4:0]         clusters_reg;
    logic               norm_reg;
    logic signed [15:0] window_q[16];
    logic signed [15:0] centroids[16][16];
    logic [23:0]        bin_tally[16];
    logic [23:0]        seen_count;

    function automatic int eff_window();
        if (win_len_reg == 0) return 1;
        if (win_len_reg > 16) return 16;
        return win_len_reg;
    endfunction

    function automatic int eff_clusters();
        if (clusters_reg == 0) return 1;
        if (clusters_reg > 16) return 16;
        return clusters_reg;
    endfunction

    function automatic void clear_histogram();
        foreach (window_q[k]) window_q[k] = '0;
        foreach (bin_tally[k]) bin_tally[k] = '0;
        seen_count = '0;
    endfunction

    // nearest centroid of the current window, lower index wins ties
    function automatic void classify_window(int len);
        longint unsigned sq_sum, best_sum, mag;
        longint          diff;
        int              best;
        best = 0;
        best_sum = '1;
        for (int c = 0; c < eff_clusters(); c++) begin
            sq_sum = 0;
            for (int j = 0; j < len; j++) begin
                diff = longint'(centroids[c][j]) - longint'(window_q[len - 1 - j]);
                mag = (diff < 0) ? -diff : diff;
                sq_sum += mag * mag;
            end
            if (c == 0 || sq_sum < best_sum) begin
                best_sum = sq_sum;
                best = c;
            end
        end
        if (bin_tally[best] != 24'hFFFFFF) bin_tally[best]++;
    endfunction

    function automatic void predict_bins(t_vq_item it);
        int              len, nc;
        longint unsigned total, val;
        t_bin_item       b;
        case (it.mode)
            swvq_pkg::ModeLoad: begin
                centroids[it.centroid][it.element] = it.value;
            end
            swvq_pkg::ModeSample: begin
                len = eff_window();
                if (seen_count >= len) classify_window(len);
                for (int k = 15; k > 0; k--) window_q[k] = window_q[k - 1];
                window_q[0] = it.value;
                if (seen_count != 24'hFFFFFF) seen_count++;
            end
            swvq_pkg::ModeEnd: begin
                nc = eff_clusters();
                total = 0;
                for (int k = 0; k < nc; k++) total += bin_tally[k];
                if (total == 0) total = 1;
                for (int k = 0; k < nc; k++) begin
                    val = bin_tally[k];
                    if (norm_reg) val = (val << 16) / total;
                    b.bin = k[3:0];
                    b.count = val[23:0];
                    b.last = (k == nc - 1);
                    bins_due = {bins_due, b};
                end
                clear_histogram();
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // monitor: predict on accepted inputs, check accepted results
    always @(posedge i_clk) begin
        t_vq_item  it;
        t_bin_item want;
        item_taken = 1'b0;
        if (!i_rst_n) begin
            win_len_reg = 5'd16;
            clusters_reg = 5'd16;
            norm_reg = 1'b0;
            clear_histogram();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    swvq_pkg::CfgWinLen: win_len_reg = i_cfg_data[4:0];
                    swvq_pkg::CfgClust:  clusters_reg = i_cfg_data[4:0];
                    swvq_pkg::CfgNorm:   norm_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                item_taken = 1'b1;
                it.mode = i_mode;
                it.centroid = i_centroid_index;
                it.element = i_element_index;
                it.value = i_value;
                predict_bins(it);
            end
            if (o_valid && i_ready) begin
                if (bins_due.size() == 0) begin
                    report("unexpected bin", o_bin_index, -1);
                end else begin
                    want = bins_due.pop_front();
                    if (o_bin_index !== want.bin) report("bin_index", o_bin_index, want.bin);
                    if (o_bin_value !== want.count)
                        report("bin_value", o_bin_value, want.count);
                    if (o_last !== want.last) report("last", o_last, want.last);
                end
            end
        end
    end

    // driver: offers queued items with random gaps
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_vq_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !item_taken) begin
            i_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (pending_items.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 4);
            i_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            i_mode <= it.mode;
            i_centroid_index <= it.centroid;
            i_element_index <= it.element;
            i_value <= it.value;
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts plus one long hold
    int stall_left = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 700;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic push_item(logic [1:0] mode, logic [3:0] ci, logic [3:0] ei,
                             logic [15:0] val);
        t_vq_item it;
        it.mode = mode;
        it.centroid = ci;
        it.element = ei;
        it.value = val;
        pending_items = {pending_items, it};
    endtask

    // mostly small values so windows land near different centroids
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_valid || bins_due.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 68)
                push_item(swvq_pkg::ModeSample, 4'($urandom), 4'($urandom), pick_value());
            else if (r < 80)
                push_item(swvq_pkg::ModeEnd, 4'($urandom), 4'($urandom), 16'($urandom));
            else if (r < 93)
                push_item(swvq_pkg::ModeLoad, 4'($urandom), 4'($urandom), pick_value());
            else push_item(ModeIgnored, 4'($urandom), 4'($urandom), 16'($urandom));
        end
        push_item(swvq_pkg::ModeEnd, 4'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // window length, clusters, normalise per phase; out-of-range values clamp.
    // A window over two elements is only used with at most two centroids,
    // as only those centroids are loaded in full.
    int phase_len[8]  = '{1, 0, 2, 1, 2, 2, 1, 0};
    int phase_nc[8]   = '{1, 0, 8, 2, 5, 31, 16, 3};
    int phase_norm[8] = '{1, 0, 1, 1, 0, 1, 0, 0};

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // clamped full-length window over two centroids for the directed part
        write_reg(swvq_pkg::CfgWinLen, 32'd31);
        write_reg(swvq_pkg::CfgClust, 32'd2);

        // two centroids in full, the rest over their first two elements
        for (int c = 0; c < 16; c++)
            for (int e = 0; e < 16; e++)
                if (c < 2 || e < 2)
                    push_item(swvq_pkg::ModeLoad, c[3:0], e[3:0],
                              (c == 0 && e == 0) ? 16'h7FFF :
                              (c == 1 && e == 15) ? 16'h8000 : pick_value());

        // directed: empty histogram, extremes, ignored mode
        push_item(swvq_pkg::ModeEnd, 4'hF, 4'hF, 16'hFFFF);
        for (int k = 0; k < 18; k++)
            push_item(swvq_pkg::ModeSample, 4'h0, 4'h0,
                      k[0] ? 16'h7FFF : (k[1] ? 16'h8000 : 16'h0000));
        push_item(ModeIgnored, 4'hF, 4'hF, 16'hFFFF);
        push_item(swvq_pkg::ModeEnd, 4'h0, 4'h0, 16'h0000);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_reg(swvq_pkg::CfgWinLen, 32'hFFFF_FFE0 | phase_len[p]);
            write_reg(swvq_pkg::CfgClust, phase_nc[p]);
            write_reg(swvq_pkg::CfgNorm, phase_norm[p]);
            if (p == 7) calm = 1'b1;
            if (p == 2) begin
                // receiver holds off while the sender keeps feeding
                @(negedge i_clk);
                long_hold_req = 1'b1;
                push_item(swvq_pkg::ModeEnd, 4'h0, 4'h0, 16'h0000);
                random_items(5);
            end else if (p == 4) begin
                // sender pauses until every result is in
                random_items(2);
                do @(posedge i_clk);
                while (pending_items.size() != 0 || i_valid || bins_due.size() != 0);
                random_items(2);
            end else begin
                random_items(5);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
